// ===== rtl/core/bdm_pkg.sv =====
// Shared types, register codes and helpers for the Bayer demosaic block.
package bdm_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int CFG_BITS   = 13;
    localparam int OUT_BITS   = 18;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int MIN_WIDTH     = 2;
    localparam int MIN_HEIGHT    = 1;
    localparam int CLAMP8_MAX    = 255;
    localparam int CLAMP10_MAX   = 1023;

    localparam int NUM_CELLS = 4;
    localparam int NUM_TAPS  = 5;
    localparam int NUM_NB    = 13;

    typedef enum logic [1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_PATTERN = 2'd2,
        REG_CLAMP   = 2'd3
    } bdm_reg_t;

    typedef enum logic [1:0] {
        PAT_RGGB = 2'd0,
        PAT_GRBG = 2'd1,
        PAT_GBRG = 2'd2,
        PAT_BGGR = 2'd3
    } bdm_pattern_t;

    typedef enum logic [1:0] {
        CLAMP_8BIT  = 2'd0,
        CLAMP_10BIT = 2'd1,
        CLAMP_NONE  = 2'd2
    } bdm_clamp_t;

    // neighbor slots of the 5x5 window
    typedef enum logic [3:0] {
        NB_C   = 4'd0,
        NB_W   = 4'd1,
        NB_E   = 4'd2,
        NB_N   = 4'd3,
        NB_S   = 4'd4,
        NB_W2  = 4'd5,
        NB_E2  = 4'd6,
        NB_N2  = 4'd7,
        NB_S2  = 4'd8,
        NB_NW  = 4'd9,
        NB_NE  = 4'd10,
        NB_SW  = 4'd11,
        NB_SE  = 4'd12
    } bdm_nb_t;

    typedef struct packed {
        logic red_row;
        logic green_site;
        logic frame_end;
    } bdm_site_t;

    function automatic int sat(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (v < lo) r = lo;
        if (v > hi) r = hi;
        return r;
    endfunction

endpackage

// ===== rtl/core/bdm_ram.sv =====
// Generic single-port-pair RAM with registered read data.
module bdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/bdm_line_cell.sv =====
// One line cell: a width-2 word delay in RAM followed by a five-tap shift line.
module bdm_line_cell #(
    parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = bdm_pkg::PIXEL_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       delay_len,
    input  logic [PIXEL_BITS-1:0]                pix_in,
    output logic [PIXEL_BITS-1:0]                taps [bdm_pkg::NUM_TAPS]
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH+1);

    logic [AW-1:0]         ptr_reg;
    logic [AW-1:0]         ptr_next;
    logic [AW-1:0]         ptr_cur;
    logic [WW-1:0]         ptr_inc;
    logic [PIXEL_BITS-1:0] ram_rd;
    logic [PIXEL_BITS-1:0] byp_reg;
    logic [PIXEL_BITS-1:0] shift_reg [1:bdm_pkg::NUM_TAPS-1];

    // restart the ring when the delay has shrunk to or below the held pointer
    assign ptr_cur  = (WW'(ptr_reg) >= delay_len) ? '0 : ptr_reg;
    assign ptr_inc  = WW'(ptr_cur) + WW'(1);
    assign ptr_next = (ptr_inc >= delay_len) ? '0 : ptr_inc[AW-1:0];

    bdm_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (adv),
        .waddr (ptr_cur),
        .wdata (pix_in),
        .re    (adv),
        .raddr (ptr_cur),
        .rdata (ram_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (adv)
        begin
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp_reg      <= pix_in;
            shift_reg[1] <= taps[0];
            for (int i = 2; i < bdm_pkg::NUM_TAPS; i++)
            begin
                shift_reg[i] <= shift_reg[i-1];
            end
        end
    end

    always_comb
    begin
        taps[0] = (delay_len == '0) ? byp_reg : ram_rd;
        for (int i = 1; i < bdm_pkg::NUM_TAPS; i++)
        begin
            taps[i] = shift_reg[i];
        end
    end

endmodule

// ===== rtl/core/bdm_kernel.sv =====
// Edge masking, partial sums and the 5x5 interpolation kernels with clamping.
module bdm_kernel #(
    parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bdm_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = bdm_pkg::PIXEL_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   win_valid,
    input  bdm_pkg::bdm_site_t                     site,
    input  logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_HEIGHT+1):0] center,
    input  logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_HEIGHT+1)-1:0] n_pix,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         w_pix,
    input  logic [PIXEL_BITS-1:0]                  win [bdm_pkg::NUM_NB],
    input  logic [1:0]                             clamp_mode,
    output logic                                   res_valid,
    output logic                                   res_end,
    output logic signed [bdm_pkg::OUT_BITS-1:0]    res_blue,
    output logic signed [bdm_pkg::OUT_BITS-1:0]    res_green,
    output logic signed [bdm_pkg::OUT_BITS-1:0]    res_red
);

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int NW = WW + $clog2(MAX_HEIGHT+1);
    localparam int KW = NW + 1;
    localparam int EW = KW + 2;
    localparam int PB = PIXEL_BITS;
    localparam int OB = bdm_pkg::OUT_BITS;
    localparam int SW = (PB + 6 > bdm_pkg::OUT_BITS) ? PB + 6 : bdm_pkg::OUT_BITS;
    localparam logic signed [EW-1:0] E_ONE = EW'(1);
    localparam logic signed [EW-1:0] E_TWO = EW'(2);
    localparam logic signed [SW-1:0] C8    = SW'(bdm_pkg::CLAMP8_MAX);
    localparam logic signed [SW-1:0] C10   = SW'(bdm_pkg::CLAMP10_MAX);

    logic signed [EW-1:0] cs;
    logic signed [EW-1:0] ws;
    logic signed [EW-1:0] ns;
    logic signed [EW-1:0] off [bdm_pkg::NUM_NB];
    logic signed [EW-1:0] pos [bdm_pkg::NUM_NB];
    logic [PB-1:0]        m   [bdm_pkg::NUM_NB];

    logic               v1_reg;
    bdm_pkg::bdm_site_t site1_reg;
    logic [PB-1:0]      ctr_reg;
    logic [PB:0]        nearh_reg;
    logic [PB:0]        nearv_reg;
    logic [PB:0]        farh_reg;
    logic [PB:0]        farv_reg;
    logic [PB+1:0]      diag_reg;

    logic signed [SW-1:0] ce;
    logic signed [SW-1:0] dg;
    logic signed [SW-1:0] fh;
    logic signed [SW-1:0] fv;
    logic signed [SW-1:0] nh;
    logic signed [SW-1:0] nv;
    logic signed [SW-1:0] f4;
    logic signed [SW-1:0] k_cross;
    logic signed [SW-1:0] k_green;
    logic signed [SW-1:0] k_row;
    logic signed [SW-1:0] k_col;
    logic signed [SW-1:0] b_raw;
    logic signed [SW-1:0] g_raw;
    logic signed [SW-1:0] r_raw;

    function automatic logic signed [SW-1:0] limit(input logic signed [SW-1:0] v,
                                                   input logic [1:0] mode);
        logic signed [SW-1:0] r;
        r = v;
        case (mode)
            bdm_pkg::CLAMP_8BIT:
            begin
                if (v < 0) r = '0;
                else if (v > C8) r = C8;
            end
            bdm_pkg::CLAMP_10BIT:
            begin
                if (v < 0) r = '0;
                else if (v > C10) r = C10;
            end
            default:
            begin
                r = v;
            end
        endcase
        return r;
    endfunction

    always_comb
    begin
        cs = $signed(EW'(center));
        ws = $signed(EW'(w_pix));
        ns = $signed(EW'(n_pix));
        off[bdm_pkg::NB_C]  = '0;
        off[bdm_pkg::NB_W]  = -E_ONE;
        off[bdm_pkg::NB_E]  = E_ONE;
        off[bdm_pkg::NB_N]  = -ws;
        off[bdm_pkg::NB_S]  = ws;
        off[bdm_pkg::NB_W2] = -E_TWO;
        off[bdm_pkg::NB_E2] = E_TWO;
        off[bdm_pkg::NB_N2] = -(ws <<< 1);
        off[bdm_pkg::NB_S2] = ws <<< 1;
        off[bdm_pkg::NB_NW] = -ws - E_ONE;
        off[bdm_pkg::NB_NE] = -ws + E_ONE;
        off[bdm_pkg::NB_SW] = ws - E_ONE;
        off[bdm_pkg::NB_SE] = ws + E_ONE;
        for (int i = 0; i < bdm_pkg::NUM_NB; i++)
        begin
            pos[i] = cs + off[i];
            m[i]   = (pos[i] >= 0 && pos[i] < ns) ? win[i] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= win_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            site1_reg <= site;
            ctr_reg   <= m[bdm_pkg::NB_C];
            nearh_reg <= (PB+1)'(m[bdm_pkg::NB_W]) + (PB+1)'(m[bdm_pkg::NB_E]);
            nearv_reg <= (PB+1)'(m[bdm_pkg::NB_N]) + (PB+1)'(m[bdm_pkg::NB_S]);
            farh_reg  <= (PB+1)'(m[bdm_pkg::NB_W2]) + (PB+1)'(m[bdm_pkg::NB_E2]);
            farv_reg  <= (PB+1)'(m[bdm_pkg::NB_N2]) + (PB+1)'(m[bdm_pkg::NB_S2]);
            diag_reg  <= (PB+2)'(m[bdm_pkg::NB_NW]) + (PB+2)'(m[bdm_pkg::NB_NE])
                       + (PB+2)'(m[bdm_pkg::NB_SW]) + (PB+2)'(m[bdm_pkg::NB_SE]);
        end
    end

    always_comb
    begin
        ce = $signed(SW'(ctr_reg));
        dg = $signed(SW'(diag_reg));
        fh = $signed(SW'(farh_reg));
        fv = $signed(SW'(farv_reg));
        nh = $signed(SW'(nearh_reg));
        nv = $signed(SW'(nearv_reg));
        f4 = fh + fv;
        k_cross = ((ce <<< 2) + (ce <<< 1) + (dg <<< 1) - (((f4 <<< 1) + f4) >>> 1)) >>> 3;
        k_green = ((ce <<< 2) + ((nh + nv) <<< 1) - f4) >>> 3;
        k_row   = ((ce <<< 2) + ce - dg - fh + (fv >>> 1) + (nh <<< 2)) >>> 3;
        k_col   = ((ce <<< 2) + ce - dg - fv + (fh >>> 1) + (nv <<< 2)) >>> 3;
        if (site1_reg.green_site)
        begin
            g_raw = ce;
            r_raw = site1_reg.red_row ? k_row : k_col;
            b_raw = site1_reg.red_row ? k_col : k_row;
        end
        else if (site1_reg.red_row)
        begin
            r_raw = ce;
            g_raw = k_green;
            b_raw = k_cross;
        end
        else
        begin
            b_raw = ce;
            g_raw = k_green;
            r_raw = k_cross;
        end
    end

    assign res_valid = v1_reg;
    assign res_end   = site1_reg.frame_end;
    assign res_blue  = OB'(limit(b_raw, clamp_mode));
    assign res_green = OB'(limit(g_raw, clamp_mode));
    assign res_red   = OB'(limit(r_raw, clamp_mode));

endmodule

// ===== rtl/core/bayer_demosaic_5x5.sv =====
// Top level of the streaming 5x5 Bayer demosaic (raw pixels in, B/G/R words out).
//
// Takes one raw pixel word per clock and, once two rows have arrived,
// gives one B/G/R word per clock: one word in, one word out, sustained
// while res_stall does not hold the output. A result word passes from the
// input registers through the kernel's partial-sum registers to the output
// register. The window is held by a chain of four line cells, each a RAM
// delay of (width - 2) words plus a five-tap shift line, one RAM write and
// one read per accepted word. Words at each frame start produce nothing
// for the first 2*width pixels, so the host follows each frame with
// 2*width flush words. An output register plus a skid word keeps the input
// open while a finished word waits; pix_stall rises only when the skid word
// is full. Registers sit on the APB port at byte offsets 0x0 width, 0x4
// height, 0x8 Bayer pattern, 0xC clamp mode; write them only while no frame
// is in flight. No clearing pass runs after reset.
module bayer_demosaic_5x5 #(
    parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bdm_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = bdm_pkg::PIXEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bdm_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [bdm_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [bdm_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  pix_valid,
    output logic                                  pix_stall,
    input  logic [15:0]                           raw_pixel,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output logic signed [bdm_pkg::OUT_BITS-1:0]   blue_out,
    output logic signed [bdm_pkg::OUT_BITS-1:0]   green_out,
    output logic signed [bdm_pkg::OUT_BITS-1:0]   red_out,
    output logic                                  frame_end
);

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);
    localparam int NW = WW + HW;
    localparam int KW = NW + 1;
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CB = bdm_pkg::CFG_BITS;
    localparam int OB = bdm_pkg::OUT_BITS;
    localparam int N_RESET =
        bdm_pkg::sat(bdm_pkg::WIDTH_RESET, bdm_pkg::MIN_WIDTH, MAX_WIDTH) *
        bdm_pkg::sat(bdm_pkg::HEIGHT_RESET, bdm_pkg::MIN_HEIGHT, MAX_HEIGHT);

    logic [CB-1:0] frame_width_reg;
    logic [CB-1:0] frame_height_reg;
    logic [1:0]    bayer_pattern_reg;
    logic [1:0]    clamp_mode_reg;
    logic          cfg_wr;
    logic [1:0]    reg_idx;

    logic [WW-1:0] w_sat;
    logic [HW-1:0] h_sat;
    logic [NW-1:0] n_next;
    logic [NW-1:0] n_reg;
    logic [WW:0]   twow;
    logic [WW-1:0] line_len;

    logic          en;
    logic          accept;
    logic          produce;
    logic          last;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] k_next;
    logic [KW-1:0] c_cur;
    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;
    logic [WW:0]   col_inc;
    logic          odd_reg;
    logic          odd_next;
    logic          red_row;
    logic          green_start;
    bdm_pkg::bdm_site_t site_cur;

    logic               v0_reg;
    bdm_pkg::bdm_site_t site0_reg;
    logic [KW-1:0]      c0_reg;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [PIXEL_BITS-1:0] pix_in;
    logic [PIXEL_BITS-1:0] taps [bdm_pkg::NUM_CELLS][bdm_pkg::NUM_TAPS];
    logic [PIXEL_BITS-1:0] cell_in [bdm_pkg::NUM_CELLS];
    logic [PIXEL_BITS-1:0] win [bdm_pkg::NUM_NB];

    logic                 k_valid;
    logic                 k_end;
    logic signed [OB-1:0] k_blue;
    logic signed [OB-1:0] k_green;
    logic signed [OB-1:0] k_red;
    logic                 push;

    logic                 out_valid_reg;
    logic signed [OB-1:0] blue_reg;
    logic signed [OB-1:0] green_reg;
    logic signed [OB-1:0] red_reg;
    logic                 end_reg;
    logic                 skid_valid_reg;
    logic signed [OB-1:0] skid_blue_reg;
    logic signed [OB-1:0] skid_green_reg;
    logic signed [OB-1:0] skid_red_reg;
    logic                 skid_end_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= CB'(bdm_pkg::WIDTH_RESET);
            frame_height_reg  <= CB'(bdm_pkg::HEIGHT_RESET);
            bayer_pattern_reg <= bdm_pkg::PAT_RGGB;
            clamp_mode_reg    <= bdm_pkg::CLAMP_8BIT;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                bdm_pkg::REG_WIDTH:   frame_width_reg   <= pwdata[CB-1:0];
                bdm_pkg::REG_HEIGHT:  frame_height_reg  <= pwdata[CB-1:0];
                bdm_pkg::REG_PATTERN: bayer_pattern_reg <= pwdata[1:0];
                bdm_pkg::REG_CLAMP:   clamp_mode_reg    <= pwdata[1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            bdm_pkg::REG_WIDTH:   prdata = 32'(frame_width_reg);
            bdm_pkg::REG_HEIGHT:  prdata = 32'(frame_height_reg);
            bdm_pkg::REG_PATTERN: prdata = 32'(bayer_pattern_reg);
            bdm_pkg::REG_CLAMP:   prdata = 32'(clamp_mode_reg);
            default:              prdata = '0;
        endcase
    end

    // frame geometry
    assign w_sat = WW'(bdm_pkg::sat(int'(frame_width_reg), bdm_pkg::MIN_WIDTH, MAX_WIDTH));
    assign h_sat = HW'(bdm_pkg::sat(int'(frame_height_reg), bdm_pkg::MIN_HEIGHT, MAX_HEIGHT));
    assign n_next   = NW'(w_sat) * NW'(h_sat);
    assign twow     = {w_sat, 1'b0};
    assign line_len = w_sat - WW'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= NW'(N_RESET);
        end
        else
        begin
            n_reg <= n_next;
        end
    end

    // position tracking
    assign en        = !skid_valid_reg;
    assign pix_stall = skid_valid_reg;
    assign accept    = pix_valid && en;
    assign produce   = k_reg >= KW'(twow);
    assign c_cur     = k_reg - KW'(twow);
    assign last      = (c_cur + KW'(1)) >= KW'(n_reg);
    assign col_inc   = (WW+1)'(col_reg) + (WW+1)'(1);

    assign red_row = (bayer_pattern_reg == bdm_pkg::PAT_RGGB ||
                      bayer_pattern_reg == bdm_pkg::PAT_GRBG) != odd_reg;
    assign green_start = (bayer_pattern_reg == bdm_pkg::PAT_GRBG ||
                          bayer_pattern_reg == bdm_pkg::PAT_GBRG) != odd_reg;
    assign site_cur.red_row    = red_row;
    assign site_cur.green_site = col_reg[0] != green_start;
    assign site_cur.frame_end  = last;

    always_comb
    begin
        k_next   = k_reg + KW'(1);
        col_next = col_reg;
        odd_next = odd_reg;
        if (produce)
        begin
            if (last)
            begin
                k_next   = '0;
                col_next = '0;
                odd_next = 1'b0;
            end
            else if (col_inc >= (WW+1)'(w_sat))
            begin
                col_next = '0;
                odd_next = !odd_reg;
            end
            else
            begin
                col_next = col_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= '0;
            col_reg <= '0;
            odd_reg <= 1'b0;
            v0_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                k_reg   <= k_next;
                col_reg <= col_next;
                odd_reg <= odd_next;
            end
            if (en)
            begin
                v0_reg <= accept && produce;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            site0_reg <= site_cur;
            c0_reg    <= c_cur;
            pix_reg   <= pix_in;
        end
    end

    // line cell chain
    assign pix_in = raw_pixel[PIXEL_BITS-1:0];

    generate
        for (genvar i = 0; i < bdm_pkg::NUM_CELLS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign cell_in[i] = pix_in;
            end
            else
            begin : g_link
                assign cell_in[i] = taps[i-1][1];
            end
            bdm_line_cell #(
                .MAX_WIDTH  (MAX_WIDTH),
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (accept),
                .delay_len (line_len),
                .pix_in    (cell_in[i]),
                .taps      (taps[i])
            );
        end
    endgenerate

    always_comb
    begin
        win[bdm_pkg::NB_C]  = taps[1][2];
        win[bdm_pkg::NB_W]  = taps[1][3];
        win[bdm_pkg::NB_E]  = taps[1][1];
        win[bdm_pkg::NB_N]  = taps[2][2];
        win[bdm_pkg::NB_S]  = taps[0][2];
        win[bdm_pkg::NB_W2] = taps[1][4];
        win[bdm_pkg::NB_E2] = taps[1][0];
        win[bdm_pkg::NB_N2] = taps[3][2];
        win[bdm_pkg::NB_S2] = pix_reg;
        win[bdm_pkg::NB_NW] = taps[2][3];
        win[bdm_pkg::NB_NE] = taps[2][1];
        win[bdm_pkg::NB_SW] = taps[0][3];
        win[bdm_pkg::NB_SE] = taps[0][1];
    end

    bdm_kernel #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_kernel (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .win_valid  (v0_reg),
        .site       (site0_reg),
        .center     (c0_reg),
        .n_pix      (n_reg),
        .w_pix      (w_sat),
        .win        (win),
        .clamp_mode (clamp_mode_reg),
        .res_valid  (k_valid),
        .res_end    (k_end),
        .res_blue   (k_blue),
        .res_green  (k_green),
        .res_red    (k_red)
    );

    // output register and skid word
    assign push = en && k_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !res_stall)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !res_stall)
        begin
            if (skid_valid_reg)
            begin
                blue_reg  <= skid_blue_reg;
                green_reg <= skid_green_reg;
                red_reg   <= skid_red_reg;
                end_reg   <= skid_end_reg;
            end
            else
            begin
                blue_reg  <= k_blue;
                green_reg <= k_green;
                red_reg   <= k_red;
                end_reg   <= k_end;
            end
        end
        else if (push)
        begin
            skid_blue_reg  <= k_blue;
            skid_green_reg <= k_green;
            skid_red_reg   <= k_red;
            skid_end_reg   <= k_end;
        end
    end

    assign res_valid = out_valid_reg;
    assign blue_out  = blue_reg;
    assign green_out = green_reg;
    assign red_out   = red_reg;
    assign frame_end = end_reg;

endmodule

// ===== rtl/core/bdm_checker.sv =====
// Port-level checker for the Bayer demosaic top level, bound to it.
module bdm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 pix_stall,
    input logic                                 res_valid,
    input logic                                 res_stall,
    input logic signed [bdm_pkg::OUT_BITS-1:0]  blue_out,
    input logic signed [bdm_pkg::OUT_BITS-1:0]  green_out,
    input logic signed [bdm_pkg::OUT_BITS-1:0]  red_out,
    input logic                                 frame_end
);

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid &&
        $stable({blue_out, green_out, red_out, frame_end}))
        else $error("result word changed while stalled");

    a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_valid)
        else $error("input stalled with no result word shown");

    a_drain_opens: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall |=> !pix_stall)
        else $error("input still stalled after result word taken");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_stall) |-> $past(res_valid && res_stall))
        else $error("input stall rose without a stalled result");

endmodule

bind bayer_demosaic_5x5 bdm_checker u_bdm_checker (.*);
